### src/mqrf_pkg.sv
// shared types and codes of the multi queue ring fifo engine
package mqrf_pkg;

  typedef enum logic [3:0] {
    FN_ALLOC    = 4'd0,
    FN_FREE     = 4'd1,
    FN_ADD      = 4'd2,
    FN_TOP      = 4'd3,
    FN_POP      = 4'd4,
    FN_GET      = 4'd5,
    FN_PUT      = 4'd6,
    FN_NEXT     = 4'd7,
    FN_SET_HEAD = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_READ,
    S_NEXT,
    S_OUT
  } state_e;

  localparam int unsigned IdBits     = 32;
  localparam int unsigned FuncBits   = 4;
  localparam int unsigned HandleBits = 5;

endpackage

### src/multi_queue_ring_fifo_engine.sv
// top level of the multi queue ring fifo engine
//
// one request enters on the s_axis group, one result leaves on m_axis.
// s_axis_tdata: func, queue_handle, seq_id, entry_value (from lowest bit up).
// m_axis_tdata: status, result_value, result_id, result_handle.
// one request is handled at a time. the head and tail counts of a queue sit
// side by side in one memory and the entries in a second, both with a
// registered read. a bad request goes straight to the result; free and
// set_head read the counts, and add, put, top, pop and get also pass a read
// state; alloc scans the in-use flags, one queue a cycle; next_live reads
// one entry a cycle from the cursor up to the tail.
// reset clears the in-use flags; counts are cleared on alloc, entries are
// undefined until written, so no clearing pass is needed.
// the result waits in an output register while the receiver stalls; the next
// request is taken in the cycle the result leaves.
module multi_queue_ring_fifo_engine #(
  parameter int unsigned NUM_QUEUES = 16,
  parameter int unsigned DEPTH      = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func[3:0], queue_handle[8:4], seq_id[40:9], entry_value[72:41]
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], result_value[33:2], result_id[65:34], result_handle[70:66]
  output logic [71:0]  m_axis_tdata
);
  import mqrf_pkg::*;

  localparam int unsigned QBits = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SBits = $clog2(DEPTH);
  localparam int unsigned ABits = QBits + SBits;
  localparam int unsigned VBits = (VALUE_BITS > 32) ? 32 : VALUE_BITS;

  state_e state_q, state_d;

  logic [FuncBits-1:0]   func_q;
  logic [QBits-1:0]      q_q, q_d;
  logic [IdBits-1:0]     sid_q, val_q, tail_q, cur_q, cur_d;
  logic [NUM_QUEUES-1:0] used_q, used_d;
  logic [1:0]            st_q, st_d;
  logic [IdBits-1:0]     rv_q, rv_d, rid_q, rid_d;
  logic [HandleBits-1:0] rh_q, rh_d;
  logic                  ovalid_q;

  logic                  cnt_we, st_we;
  logic [IdBits-1:0]     head_w, tail_w, head_r, tail_r, st_wdata, st_rdata;
  logic [2*IdBits-1:0]   cnt_r;
  logic [QBits-1:0]      cnt_addr;
  logic [ABits-1:0]      st_addr;
  logic [IdBits-1:0]     slot_id;

  logic                  take;
  logic [HandleBits-1:0] in_hnd;
  logic                  bad_in;
  logic                  next_stop;

  assign take          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && (!ovalid_q || m_axis_tready);
  assign in_hnd        = s_axis_tdata[8:4];
  assign bad_in = (s_axis_tdata[3:0] > FN_SET_HEAD) || (in_hnd == '0) ||
                  (32'(in_hnd) > NUM_QUEUES) ||
                  !used_q[QBits'(32'(in_hnd) - 32'd1)];

  // head in the low half, tail in the high half
  mqrf_ram #(.Width(2 * IdBits), .Depth(NUM_QUEUES)) u_cnt (
    .clk_i, .we_i(cnt_we), .addr_i(cnt_addr), .wdata_i({tail_w, head_w}), .rdata_o(cnt_r)
  );
  mqrf_ram #(.Width(IdBits), .Depth(NUM_QUEUES * DEPTH)) u_store (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(st_wdata), .rdata_o(st_rdata)
  );

  assign head_r  = cnt_r[IdBits-1:0];
  assign tail_r  = cnt_r[2*IdBits-1:IdBits];
  assign st_addr = {q_q, slot_id[SBits-1:0]};

  assign next_stop = (state_q == S_NEXT) && (cur_q < tail_q) && (st_rdata != '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (s_axis_tdata[3:0] == FN_ALLOC) state_d = S_SCAN;
          else if (bad_in)                   state_d = S_OUT;
          else                               state_d = S_EXEC;
        end
      end
      S_SCAN: begin
        if (!used_q[q_q] || 32'(q_q) == NUM_QUEUES - 1) state_d = S_OUT;
      end
      S_EXEC: begin
        unique case (func_q)
          FN_FREE, FN_SET_HEAD: state_d = S_OUT;
          FN_NEXT: state_d = S_NEXT;
          default: state_d = S_READ;
        endcase
      end
      S_READ: state_d = S_OUT;
      S_NEXT: begin
        if (cur_q >= tail_q || next_stop) state_d = S_OUT;
      end
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // head/tail of the memory read are registered and appear in the cycle after the request
  always_comb begin
    logic [IdBits-1:0] h, t, s;
    h        = head_r;
    t        = tail_r;
    s        = sid_q;
    cnt_we   = 1'b0;
    cnt_addr = take ? QBits'(32'(in_hnd) - 32'd1) : q_q;
    head_w   = h;
    tail_w   = t;
    st_we    = 1'b0;
    st_wdata = val_q;
    slot_id  = cur_q;
    q_d      = q_q;
    cur_d    = cur_q;
    used_d   = used_q;
    st_d     = st_q;
    rv_d     = rv_q;
    rid_d    = rid_q;
    rh_d     = rh_q;
    if (take) begin
      q_d  = QBits'(32'(in_hnd) - 32'd1);
      st_d = bad_in ? ST_BAD : ST_OK;
      rv_d = '0;
      rid_d = '0;
      rh_d = '0;
      if (s_axis_tdata[3:0] == FN_ALLOC) begin
        q_d  = '0;
        st_d = ST_OK;
      end
    end
    unique case (state_q)
      S_SCAN: begin
        if (!used_q[q_q]) begin
          used_d[q_q] = 1'b1;
          cnt_we      = 1'b1;
          cnt_addr    = q_q;
          head_w      = '0;
          tail_w      = '0;
          rh_d        = HandleBits'(32'(q_q) + 32'd1);
        end else if (32'(q_q) == NUM_QUEUES - 1) begin
          st_d = ST_FULL;
        end else begin
          q_d = q_q + 1'b1;
        end
      end
      S_EXEC: begin
        cur_d = (s < h) ? h : s;
        unique case (func_q)
          FN_FREE: begin
            used_d[q_q] = 1'b0;
            cnt_we = 1'b1;
            head_w = '0;
            tail_w = '0;
          end
          FN_ADD: begin
            if ((t - h) >= DEPTH || t == '1) begin
              st_d = ST_FULL;
            end else begin
              slot_id  = t;
              st_we    = 1'b1;
              st_wdata = IdBits'(val_q[VBits-1:0]);
              cnt_we   = 1'b1;
              tail_w   = t + 1'b1;
              rid_d    = t + 1'b1;
            end
          end
          FN_TOP, FN_POP: begin
            slot_id = h;
            if (h < t) begin
              if (func_q == FN_POP) begin
                cnt_we = 1'b1;
                head_w = h + 1'b1;
              end
            end else begin
              st_d = ST_EMPTY;
            end
          end
          FN_GET, FN_PUT: begin
            slot_id = s - 1'b1;
            if (s > h && s <= t) begin
              if (func_q == FN_PUT) begin
                st_we    = 1'b1;
                st_wdata = IdBits'(val_q[VBits-1:0]);
              end
            end else begin
              st_d = ST_EMPTY;
            end
          end
          FN_NEXT: begin
            slot_id = (s < h) ? h : s;
            st_d    = ST_EMPTY;
            rid_d   = t + 1'b1;
          end
          default: begin
            if (s == '0 || (s - 1'b1) > t || (t - (s - 1'b1)) > DEPTH) begin
              st_d = ST_EMPTY;
            end else begin
              cnt_we = 1'b1;
              head_w = s - 1'b1;
            end
          end
        endcase
      end
      S_READ: begin
        if (st_q == ST_OK && (func_q == FN_TOP || func_q == FN_POP ||
                              func_q == FN_GET)) begin
          rv_d = st_rdata;
        end
      end
      S_NEXT: begin
        // st_rdata holds entry at cur_q; address the following slot
        if (cur_q < tail_q) begin
          if (st_rdata != '0) begin
            st_d  = ST_OK;
            rv_d  = st_rdata;
            rid_d = cur_q + 1'b1;
            cur_d = cur_q + 1'b1;
          end else begin
            cur_d   = cur_q + 1'b1;
            slot_id = cur_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (state_q == S_OUT)                 ovalid_q <= 1'b1;
      else if (m_axis_tready && ovalid_q)   ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    cur_q <= cur_d;
    st_q  <= st_d;
    rv_q  <= rv_d;
    rid_q <= rid_d;
    rh_q  <= rh_d;
    if (take) begin
      func_q <= s_axis_tdata[3:0];
      sid_q  <= s_axis_tdata[40:9];
      val_q  <= s_axis_tdata[72:41];
    end
    if (state_q == S_EXEC) begin
      tail_q <= tail_r;
    end
    if (state_q == S_OUT) begin
      m_axis_tdata <= {1'b0, rh_q, rid_q, rv_q, st_q};
    end
  end

  assign m_axis_tvalid = ovalid_q;

endmodule

### src/mqrf_ram.sv
// generic single port ram with registered read
module mqrf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### test/multi_queue_ring_fifo_engine_chk.sv
// checker for the ring fifo engine: predicts each result and compares it
module multi_queue_ring_fifo_engine_chk
  import mqrf_pkg::*;
#(
  parameter int unsigned NUM_QUEUES = 16,
  parameter int unsigned DEPTH      = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic [4:0]  handle;
    logic [31:0] id;
    logic [31:0] value;
    status_e     status;
  } result_t;

  bit          in_use [NUM_QUEUES];
  logic [31:0] head_q [NUM_QUEUES];
  logic [31:0] tail_q [NUM_QUEUES];
  logic [31:0] ring_q [NUM_QUEUES][DEPTH];

  result_t awaited_q[$];
  int      fail_cnt;
  int      status_seen[4];
  int      func_seen[16];

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = awaited_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    fail_cnt++;
  endtask

  // one request applied to the queue pool
  task automatic apply_request(input logic [79:0] req, output result_t r);
    logic [3:0]     fn;
    logic [4:0]     h;
    longint unsigned sid, hd, tl, cur;
    logic [31:0]    val, v;
    int             q;
    fn  = req[3:0];
    h   = req[8:4];
    sid = 64'(req[40:9]);
    val = req[72:41];
    r   = '0;
    r.status = ST_OK;
    func_seen[fn]++;
    if (fn == FN_ALLOC) begin
      r.status = ST_FULL;
      for (int k = 0; k < NUM_QUEUES; k++) begin
        if (!in_use[k]) begin
          in_use[k] = 1;
          head_q[k] = '0;
          tail_q[k] = '0;
          r.handle  = 5'(k + 1);
          r.status  = ST_OK;
          break;
        end
      end
    end else if (fn > FN_SET_HEAD || h == 0 || h > NUM_QUEUES || !in_use[h-1]) begin
      r.status = ST_BAD;
    end else begin
      q  = h - 1;
      hd = 64'(head_q[q]);
      tl = 64'(tail_q[q]);
      case (func_e'(fn))
        FN_FREE: begin
          head_q[q] = '0;
          tail_q[q] = '0;
          in_use[q] = 0;
        end
        FN_ADD: begin
          if (tl - hd >= DEPTH || tl >= 64'hFFFF_FFFF) r.status = ST_FULL;
          else begin
            ring_q[q][tl % DEPTH] = val;
            tail_q[q] = 32'(tl + 1);
            r.id = 32'(tl + 1);
          end
        end
        FN_TOP, FN_POP: begin
          if (hd < tl) begin
            r.value = ring_q[q][hd % DEPTH];
            if (fn == FN_POP) head_q[q] = 32'(hd + 1);
          end else r.status = ST_EMPTY;
        end
        FN_GET, FN_PUT: begin
          if (sid > hd && sid <= tl) begin
            if (fn == FN_GET) r.value = ring_q[q][(sid-1) % DEPTH];
            else ring_q[q][(sid-1) % DEPTH] = val;
          end else r.status = ST_EMPTY;
        end
        FN_NEXT: begin
          cur = (sid < hd) ? hd : sid;
          r.status = ST_EMPTY;
          r.id = 32'(tl + 1);
          while (cur < tl) begin
            v = ring_q[q][cur % DEPTH];
            cur++;
            if (v != 0) begin
              r.status = ST_OK;
              r.value  = v;
              r.id     = 32'(cur);
              break;
            end
          end
        end
        default: begin
          if (sid == 0 || sid - 1 > tl || tl - (sid - 1) > DEPTH) r.status = ST_EMPTY;
          else head_q[q] = 32'(sid - 1);
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want, got;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_QUEUES; k++) begin
        in_use[k] = 0;
        head_q[k] = '0;
        tail_q[k] = '0;
      end
      awaited_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'({m_axis_tdata[70:66], m_axis_tdata[65:34], m_axis_tdata[33:2],
                         m_axis_tdata[1:0]});
        if (awaited_q.size() == 0) begin
          $display("mismatch at %0t: result with nothing expected", $time);
          fail_cnt++;
        end else begin
          want = awaited_q.pop_front();
          status_seen[want.status]++;
          if (got.status !== want.status) report("status", got.status, want.status);
          if (got.value !== want.value) report("result_value", got.value, want.value);
          if (got.id !== want.id) report("result_id", got.id, want.id);
          if (got.handle !== want.handle) report("result_handle", got.handle, want.handle);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(s_axis_tdata, want);
        awaited_q.push_back(want);
      end
    end
  end

  initial fail_cnt = 0;

endmodule

### test/multi_queue_ring_fifo_engine_tb.sv
// testbench top of the ring fifo engine: stimulus, stalls and verdict
module multi_queue_ring_fifo_engine_tb;
  import mqrf_pkg::*;

  localparam int unsigned NQ = 16;
  localparam int unsigned DP = 64;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [71:0] m_axis_tdata;
  int          fail_cnt, pending;
  int          burst_left;
  bit          done;

  multi_queue_ring_fifo_engine #(.NUM_QUEUES(NQ), .DEPTH(DP)) u_top (.*);

  multi_queue_ring_fifo_engine_chk #(.NUM_QUEUES(NQ), .DEPTH(DP)) u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall pattern, changing between three randomly chosen modes
  initial begin
    int mode;
    m_axis_tready = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (200) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  task automatic send(input func_e fn, input logic [4:0] h, input logic [31:0] sid,
                      input logic [31:0] val, input bit raw_fn = 0,
                      input logic [3:0] fn_raw = '0);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {7'd0, val, sid, h, raw_fn ? fn_raw : 4'(fn)};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [4:0] pick_handle();
    int live[$];
    for (int k = 0; k < NQ; k++) if (u_chk.in_use[k]) live.push_back(k + 1);
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
    if (live.size() == 0) return 5'($urandom_range(1, NQ));
    return 5'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  function automatic logic [31:0] pick_id(input logic [4:0] h);
    longint unsigned lo, hi;
    if (h == 0 || h > NQ) return $urandom;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
    lo = u_chk.head_q[h-1];
    hi = u_chk.tail_q[h-1];
    lo = (lo > 2) ? lo - 2 : 0;
    return 32'(lo + $urandom_range(0, hi + 3 - lo));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    func_e      fn;
    logic [4:0] h;
    int         w, profile;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    rst_ni        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed requests
    send(FN_ALLOC, 0, 0, 0, 1, 4'd9);
    send(FN_TOP, 5'd0, 0, 0);
    send(FN_TOP, 5'd1, 0, 0);
    send(FN_ALLOC, 5'd31, 0, 0);
    send(FN_TOP, 5'd1, 0, 0);
    send(FN_ADD, 5'd1, 0, 32'hFFFF_FFFF);
    send(FN_ADD, 5'd1, 0, 32'h0);
    send(FN_ADD, 5'd1, 0, 32'h1);
    send(FN_GET, 5'd1, 32'd1, 0);
    send(FN_PUT, 5'd1, 32'd3, 32'h8000_0000);
    send(FN_NEXT, 5'd1, 32'd1, 0);
    send(FN_NEXT, 5'd1, 32'd2, 0);
    send(FN_POP, 5'd1, 0, 0);
    send(FN_SET_HEAD, 5'd1, 32'd0, 0);
    send(FN_SET_HEAD, 5'd1, 32'd1, 0);
    send(FN_GET, 5'd1, 32'd4, 0);
    send(FN_GET, 5'd1, 32'hFFFF_FFFF, 0);
    send(FN_SET_HEAD, 5'd1, 32'd5, 0);
    send(FN_NEXT, 5'd1, 32'hFFFF_FFFF, 0);
    send(FN_FREE, 5'd1, 0, 0);
    send(FN_FREE, 5'd1, 0, 0);
    send(FN_ALLOC, 5'd17, 0, 0, 1, 4'd15);

    // random phases: mixed, filling, pool churn
    for (int n = 0; n < 1100; n++) begin
      profile = (n / 110) % 3;
      w = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) begin
        send(FN_ALLOC, pick_handle(), $urandom, $urandom, 1, 4'($urandom_range(9, 15)));
        continue;
      end
      case (profile)
        1: fn = (w < 70) ? FN_ADD : (w < 80) ? FN_NEXT : (w < 90) ? FN_GET : FN_PUT;
        2: fn = (w < 40) ? FN_ALLOC : (w < 60) ? FN_FREE : (w < 80) ? FN_ADD : FN_POP;
        default: fn = (w < 8)  ? FN_ALLOC : (w < 12) ? FN_FREE : (w < 40) ? FN_ADD :
                      (w < 48) ? FN_TOP   : (w < 58) ? FN_POP  : (w < 68) ? FN_GET :
                      (w < 78) ? FN_PUT   : (w < 90) ? FN_NEXT : FN_SET_HEAD;
      endcase
      h = pick_handle();
      send(fn, h, pick_id(h), pick_value());
    end
    s_axis_tvalid <= 0;
    done = 1;
  end

  initial begin
    done = 0;
    wait (done);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d adds, %0d next_live scans, %0d allocs",
             u_chk.func_seen[FN_ADD], u_chk.func_seen[FN_NEXT], u_chk.func_seen[FN_ALLOC]);
    $display("statuses ok %0d, empty %0d, full %0d, bad %0d",
             u_chk.status_seen[0], u_chk.status_seen[1], u_chk.status_seen[2],
             u_chk.status_seen[3]);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
